FILE: rtl/mandelbrot_escape_pixel_defines.svh
// Assertion macros for the escape-time pixel block.
`ifndef MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_PIXEL_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define MEP_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mep: same-cycle check failed");
`define MEP_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mep: next-cycle check failed");
`else
`define MEP_ASSERT_IMP(name, ante, cons)
`define MEP_ASSERT_NXT(name, ante, cons)
`endif

`endif

FILE: rtl/mep_pkg.sv
`timescale 1ns / 1ps

package mep_pkg;

   localparam int MAX_ITER_DEF  = 2048;
   localparam int FRAC_BITS_DEF = 24;

   // widest count over the MAX_ITER range, and width of the red thresholds
   localparam int THR_W = 17;

   localparam int CSR_ADDR_W = 4;
   localparam int SUM_W      = 66;

   localparam logic [1:0] REG_LEFT_X = 2'd0;
   localparam logic [1:0] REG_TOP_Y  = 2'd1;
   localparam logic [1:0] REG_STEP   = 2'd2;

   localparam logic signed [31:0] LEFT_X_RST = -32'sd1962500000;
   localparam logic signed [31:0] TOP_Y_RST  = -32'sd6291456;
   localparam logic [30:0]        STEP_RST   = 31'd20972;

   localparam logic [31:0] PIX_ALPHA  = 32'hff00_0000;
   localparam logic [7:0]  GREEN_ODD  = 8'h40;
   localparam logic [7:0]  GREEN_EVEN = 8'hb0;
   localparam logic [31:0] BLUE_BASE  = 32'd265;

   // 255^4
   localparam logic [63:0] RED_DEN = 64'd4228250625;

   typedef logic [THR_W-1:0] red_thr_type [256];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MCX,
      ST_MCY,
      ST_SETC,
      ST_MXX,
      ST_MYY,
      ST_MXY,
      ST_UPD,
      ST_RGO,
      ST_RED,
      ST_FIN
   } mep_state_type;

   // smallest count that reaches each red level: ceil(r^4 * max_iter / 255^4)
   function automatic red_thr_type red_thr(input int unsigned max_iter);
      red_thr_type tab;
      logic [63:0] r4;
      for (int r = 0; r < 256; r++) begin
         r4 = 64'(r) * 64'(r) * 64'(r) * 64'(r);
         tab[r] = THR_W'((r4 * 64'(max_iter) + RED_DEN - 64'd1) / RED_DEN);
      end
      return tab;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [31:0] r;
      if (v > SUM_W'(signed'(32'sh7fff_ffff))) begin
         r = 32'sh7fff_ffff;
      end else if (v < SUM_W'(signed'(32'sh8000_0000))) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/mep_if.sv
`timescale 1ns / 1ps

interface mep_req_if;
   logic        valid;
   logic        ready;
   logic [11:0] column;
   logic [11:0] row;

   modport source (output valid, output column, output row, input ready);
   modport sink   (input valid, input column, input row, output ready);
endinterface

interface mep_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] iterations;
   logic [31:0] pixel;

   modport source (output valid, output iterations, output pixel, input ready);
   modport sink   (input valid, input iterations, input pixel, output ready);
endinterface

FILE: rtl/mep_red.sv
`timescale 1ns / 1ps

// Red level search: one threshold compare per cycle, one red bit per compare, MSB first.
module mep_red #(
   parameter int MAX_ITER = mep_pkg::MAX_ITER_DEF,
   parameter int CNT_W    = $clog2(MAX_ITER + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [CNT_W-1:0] count,
   output logic             done,
   output logic [7:0]       red
);

   localparam mep_pkg::red_thr_type THR = mep_pkg::red_thr(MAX_ITER);

   logic       active_ff, active_in;
   logic       done_ff, done_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] trial;
   logic [mep_pkg::THR_W-1:0] count_ext;

   assign count_ext = mep_pkg::THR_W'(count);
   assign trial     = red_ff | (8'd1 << bit_ff);

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      bit_in    = bit_ff;
      red_in    = red_ff;
      if (start) begin
         active_in = 1'b1;
         bit_in    = 3'd7;
         red_in    = 8'd0;
      end else if (active_ff) begin
         if (count_ext >= THR[trial]) begin
            red_in = trial;
         end
         if (bit_ff == 3'd0) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end else begin
            bit_in = bit_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         bit_ff    <= 3'd0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         bit_ff    <= bit_in;
      end
      red_ff <= red_in;
   end

   assign done = done_ff;
   assign red  = red_ff;

endmodule

FILE: rtl/mandelbrot_escape_pixel.sv
// Mandelbrot escape-time pixel unit. A request item carries a pixel column and row; the
// block forms c = (left_x + column*step, top_y + row*step) in signed fixed point with
// FRAC_BITS fraction bits, iterates z = z^2 + c from z = c, and returns the count of
// iterations with |z|^2 <= 100 (capped at MAX_ITER) and an ARGB colour built from it.
// One item is in work at a time. A single 32x32 multiplier does all products: three per
// iteration (x^2, y^2, x*y) plus a separate z update step. The colour's red level comes
// from an eight-step threshold search. A finished result waits in the output register;
// the block returns to idle as it is loaded and can take the next item while it waits.
// Registers (APB, byte address): 0x0 left_x, 0x4 top_y, 0x8 step; write them only while
// no item is in work.
`timescale 1ns / 1ps
`include "mandelbrot_escape_pixel_defines.svh"

module mandelbrot_escape_pixel #(
   parameter int MAX_ITER  = mep_pkg::MAX_ITER_DEF,
   parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   mep_req_if.sink                        req,
   mep_rsp_if.source                      rsp,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mep_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam int CNT_W = $clog2(MAX_ITER + 1);
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ITER);
   localparam logic [64:0]      LIMIT     = 65'd100 << (2 * FRAC_BITS);
   localparam logic [31:0]      MAG_BOUND = 32'(64'd10 << FRAC_BITS);

   // configuration registers
   logic signed [31:0] left_ff, top_ff;
   logic [30:0]        step_ff;
   logic               csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= mep_pkg::LEFT_X_RST;
         top_ff  <= mep_pkg::TOP_Y_RST;
         step_ff <= mep_pkg::STEP_RST;
      end else if (csr_wr) begin
         case (paddr[3:2])
            mep_pkg::REG_LEFT_X: left_ff <= pwdata;
            mep_pkg::REG_TOP_Y:  top_ff  <= pwdata;
            mep_pkg::REG_STEP:   step_ff <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         mep_pkg::REG_LEFT_X: prdata = left_ff;
         mep_pkg::REG_TOP_Y:  prdata = top_ff;
         mep_pkg::REG_STEP:   prdata = {1'b0, step_ff};
         default:             prdata = 32'd0;
      endcase
   end

   // sequencer and datapath
   mep_pkg::mep_state_type state_ff, state_in;

   logic [11:0]        col_ff, col_in, row_ff, row_in;
   logic signed [31:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        x2_ff, x2_in;
   logic signed [64:0] re_ff, re_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [11:0]        rsp_iter_ff, rsp_iter_in;
   logic [31:0]        rsp_pix_ff, rsp_pix_in;

   logic [31:0] mul_a, mul_b;
   logic [31:0] ax, ay;
   logic signed [31:0] c_base;
   logic signed [mep_pkg::SUM_W-1:0] c_sum;
   logic [64:0] mag;
   logic        escape;
   logic signed [mep_pkg::SUM_W-1:0] re_ext, re_sh, im_pos, im_s, im_sh;
   logic signed [mep_pkg::SUM_W-1:0] cx_ext, cy_ext;
   logic        neg;
   logic [CNT_W+11:0] count_wide;
   logic        red_start, red_done;
   logic [7:0]  red, green;

   assign ax = x_ff[31] ? (32'd0 - x_ff) : x_ff;
   assign ay = y_ff[31] ? (32'd0 - y_ff) : y_ff;

   // operand select for the shared multiplier
   always_comb begin
      case (state_ff)
         mep_pkg::ST_MCX: begin
            mul_a = {20'd0, col_ff};
            mul_b = {1'b0, step_ff};
         end
         mep_pkg::ST_MCY: begin
            mul_a = {20'd0, row_ff};
            mul_b = {1'b0, step_ff};
         end
         mep_pkg::ST_MXX: begin
            mul_a = ax;
            mul_b = ax;
         end
         mep_pkg::ST_MYY: begin
            mul_a = ay;
            mul_b = ay;
         end
         mep_pkg::ST_MXY: begin
            mul_a = ax;
            mul_b = ay;
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 32'd0;
         end
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   // c = base + index * step, saturated
   assign c_base = (state_ff == mep_pkg::ST_MCY) ? left_ff : top_ff;
   assign c_sum  = {{34{c_base[31]}}, c_base} + {2'b00, prod_ff};

   // escape test: x^2 held, y^2 just out of the multiplier
   assign mag    = {1'b0, x2_ff} + {1'b0, prod_ff};
   assign escape = mag > LIMIT;

   // z update
   assign re_ext = {re_ff[64], re_ff};
   assign re_sh  = re_ext >>> FRAC_BITS;
   assign neg    = x_ff[31] ^ y_ff[31];
   assign im_pos = {1'b0, prod_ff, 1'b0};
   assign im_s   = neg ? -im_pos : im_pos;
   assign im_sh  = im_s >>> FRAC_BITS;
   assign cx_ext = {{34{cx_ff[31]}}, cx_ff};
   assign cy_ext = {{34{cy_ff[31]}}, cy_ff};

   assign count_wide = {12'd0, count_ff};
   assign green      = red[0] ? mep_pkg::GREEN_ODD : mep_pkg::GREEN_EVEN;

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      x2_in        = x2_ff;
      re_in        = re_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_iter_in  = rsp_iter_ff;
      rsp_pix_in   = rsp_pix_ff;
      red_start    = 1'b0;
      req.ready    = 1'b0;

      // drop the held result once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         mep_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               col_in   = req.column;
               row_in   = req.row;
               count_in = '0;
               state_in = mep_pkg::ST_MCX;
            end
         end
         mep_pkg::ST_MCX: begin
            state_in = mep_pkg::ST_MCY;
         end
         mep_pkg::ST_MCY: begin
            cx_in    = mep_pkg::sat32(c_sum);
            x_in     = mep_pkg::sat32(c_sum);
            state_in = mep_pkg::ST_SETC;
         end
         mep_pkg::ST_SETC: begin
            cy_in    = mep_pkg::sat32(c_sum);
            y_in     = mep_pkg::sat32(c_sum);
            state_in = mep_pkg::ST_MXX;
         end
         mep_pkg::ST_MXX: begin
            state_in = mep_pkg::ST_MYY;
         end
         mep_pkg::ST_MYY: begin
            x2_in    = prod_ff;
            state_in = mep_pkg::ST_MXY;
         end
         mep_pkg::ST_MXY: begin
            re_in = {1'b0, x2_ff} - {1'b0, prod_ff};
            if (escape) begin
               state_in = mep_pkg::ST_RGO;
            end else begin
               count_in = count_ff + CNT_W'(1);
               state_in = mep_pkg::ST_UPD;
            end
         end
         mep_pkg::ST_UPD: begin
            x_in = mep_pkg::sat32(re_sh + cx_ext);
            y_in = mep_pkg::sat32(im_sh + cy_ext);
            if (count_ff == CNT_MAX) begin
               state_in = mep_pkg::ST_RGO;
            end else begin
               state_in = mep_pkg::ST_MXX;
            end
         end
         mep_pkg::ST_RGO: begin
            red_start = 1'b1;
            state_in  = mep_pkg::ST_RED;
         end
         mep_pkg::ST_RED: begin
            if (red_done) begin
               state_in = mep_pkg::ST_FIN;
            end
         end
         mep_pkg::ST_FIN: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_iter_in  = count_wide[11:0];
               rsp_pix_in   = mep_pkg::PIX_ALPHA + {8'd0, red, 16'd0} + {16'd0, green, 8'd0}
                              + (mep_pkg::BLUE_BASE - {24'd0, red});
               state_in     = mep_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mep_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mep_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff      <= col_in;
      row_ff      <= row_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      prod_ff     <= prod_in;
      x2_ff       <= x2_in;
      re_ff       <= re_in;
      rsp_iter_ff <= rsp_iter_in;
      rsp_pix_ff  <= rsp_pix_in;
   end

   mep_red #(
      .MAX_ITER (MAX_ITER),
      .CNT_W    (CNT_W)
   ) u_red (
      .clock (clock),
      .reset (reset),
      .start (red_start),
      .count (count_ff),
      .done  (red_done),
      .red   (red)
   );

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.iterations = rsp_iter_ff;
   assign rsp.pixel      = rsp_pix_ff;

   `MEP_ASSERT_IMP(a_count_bound, state_ff != mep_pkg::ST_IDLE, count_ff <= CNT_MAX)
   `MEP_ASSERT_IMP(a_mag_bound, state_ff == mep_pkg::ST_UPD, ax <= MAG_BOUND && ay <= MAG_BOUND)
   `MEP_ASSERT_IMP(a_rsp_source, $rose(rsp_valid_ff), $past(state_ff) == mep_pkg::ST_FIN)

endmodule
